[hdl/satsl_pkg.sv]
// Package of the set-associative tag store: default sizes, controller states
// and the command bundle from the controller to the datapath. No dependencies.
package satsl_pkg;

  localparam int unsigned DefSets       = 64;
  localparam int unsigned DefWays       = 4;
  localparam int unsigned DefBlockBytes = 64;
  localparam int unsigned DefAgeBits    = 4;
  localparam int unsigned DefAddrBits   = 32;

  localparam int unsigned AddrW = 32;
  localparam int unsigned WayOutW = 2;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StLookup = 3'b010,
    StResp   = 3'b100
  } state_e;

  typedef struct packed {
    logic accept;
    logic lookup;
  } cmd_t;

endpackage

[hdl/satsl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module satsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/satsl_ctrl.sv]
// Controller of the tag store: accept, lookup and response sequencing.
// Depends on satsl_pkg.
module satsl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output satsl_pkg::cmd_t cmd_o
);

  satsl_pkg::state_e state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == satsl_pkg::StIdle) ||
                       ((state_q == satsl_pkg::StResp) && out_ready_i);
  assign out_valid_o = (state_q == satsl_pkg::StResp);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.accept = accept;
  assign cmd_o.lookup = (state_q == satsl_pkg::StLookup);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      satsl_pkg::StIdle: begin
        if (accept) state_d = satsl_pkg::StLookup;
      end
      satsl_pkg::StLookup: begin
        state_d = satsl_pkg::StResp;
      end
      satsl_pkg::StResp: begin
        if (accept) state_d = satsl_pkg::StLookup;
        else if (out_ready_i) state_d = satsl_pkg::StIdle;
      end
      default: state_d = satsl_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= satsl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/satsl_dp.sv]
// Datapath of the tag store: set RAM, row-written flags, tag compare, victim
// choice, age update and result registers. Depends on satsl_pkg, satsl_ram.
module satsl_dp #(
  parameter int unsigned Sets       = satsl_pkg::DefSets,
  parameter int unsigned Ways       = satsl_pkg::DefWays,
  parameter int unsigned BlockBytes = satsl_pkg::DefBlockBytes,
  parameter int unsigned AgeBits    = satsl_pkg::DefAgeBits,
  parameter int unsigned AddrBits   = satsl_pkg::DefAddrBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  satsl_pkg::cmd_t                   cmd_i,
  input  logic                              op_i,
  input  logic [satsl_pkg::AddrW-1:0]       addr_i,
  output logic                              hit_o,
  output logic [satsl_pkg::WayOutW-1:0]     way_o,
  output logic                              writeback_o,
  output logic [satsl_pkg::AddrW-1:0]       writeback_addr_o
);

  localparam int unsigned AW      = satsl_pkg::AddrW;
  localparam int unsigned OffBits = $clog2(BlockBytes + 1) - 1;
  localparam int unsigned SetBits = $clog2(Sets + 1) - 1;
  localparam int unsigned SetW    = (SetBits > 0) ? SetBits : 1;
  localparam int unsigned Rows    = 1 << SetBits;
  localparam int unsigned Shift   = OffBits + SetBits;
  localparam int unsigned EffAddr = (AddrBits < AW) ? AddrBits : AW;
  localparam int unsigned TagW    = (EffAddr > Shift) ? EffAddr - Shift : 1;
  localparam int unsigned WayW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned EntW    = TagW + AgeBits + 2;
  localparam int unsigned RowW    = Ways * EntW;
  localparam logic [AgeBits-1:0] AgeMax = '1;
  localparam logic [AW-1:0] AddrMask =
    (AddrBits >= AW) ? '1 : AW'((64'd1 << AddrBits) - 64'd1);
  localparam logic [AW-1:0] SetMask = AW'((64'd1 << SetBits) - 64'd1);

  logic [AW-1:0]   addr_m;
  logic [SetW-1:0] set_in;
  logic            op_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic [Rows-1:0] init_q;
  logic [RowW-1:0] rdata, wdata;

  logic [TagW-1:0]    tg   [Ways];
  logic [AgeBits-1:0] ag   [Ways];
  logic               vl   [Ways];
  logic               dt   [Ways];
  logic [AgeBits-1:0] ag_n [Ways];
  logic               vl_n [Ways];
  logic               dt_n [Ways];
  logic [TagW-1:0]    tg_n [Ways];

  logic               hit, wb, found, row_ok;
  logic [WayW-1:0]    way;
  logic [AgeBits-1:0] best, target;
  logic [AW-1:0]      wba;

  logic                          hit_q, wb_q;
  logic [satsl_pkg::WayOutW-1:0] way_q;
  logic [AW-1:0]                 wba_q;

  assign addr_m = addr_i & AddrMask;
  assign set_in = SetW'((addr_m >> OffBits) & SetMask);

  satsl_ram #(
    .Width (RowW),
    .Depth (Rows)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.lookup),
    .waddr_i (set_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (set_in),
    .rdata_o (rdata)
  );

  assign row_ok = init_q[set_q];

  always_comb begin
    for (int i = 0; i < Ways; i++) begin
      vl[i] = row_ok & rdata[i*EntW];
      dt[i] = row_ok & rdata[i*EntW+1];
      ag[i] = row_ok ? rdata[i*EntW+2 +: AgeBits] : '0;
      tg[i] = rdata[i*EntW+2+AgeBits +: TagW];
    end
  end

  always_comb begin
    hit   = 1'b0;
    found = 1'b0;
    way   = '0;
    best  = '0;
    wb    = 1'b0;
    wba   = '0;
    for (int i = 0; i < Ways; i++) begin
      vl_n[i] = vl[i];
      dt_n[i] = dt[i];
      tg_n[i] = tg[i];
    end
    for (int i = 0; i < Ways; i++) begin
      if (!hit && vl[i] && (tg[i] == tag_q)) begin
        hit = 1'b1;
        way = WayW'(i);
      end
    end
    if (!hit) begin
      for (int i = 0; i < Ways; i++) begin
        if (!found) begin
          if (!vl[i]) begin
            found = 1'b1;
            way   = WayW'(i);
          end else if (ag[i] > best) begin
            best = ag[i];
            way  = WayW'(i);
          end
        end
      end
      if (!found && dt[way]) begin
        wb  = 1'b1;
        wba = (AW'(tg[way]) << Shift) | (AW'(set_q) << OffBits);
      end
      tg_n[way] = tag_q;
      vl_n[way] = 1'b1;
      dt_n[way] = 1'b0;
    end
    if (op_q) dt_n[way] = 1'b1;
    target = ag[way];
    for (int i = 0; i < Ways; i++) begin
      if ((ag[i] <= target) && (ag[i] != AgeMax)) ag_n[i] = ag[i] + 1'b1;
      else ag_n[i] = ag[i];
    end
    ag_n[way] = '0;
    for (int i = 0; i < Ways; i++) begin
      wdata[i*EntW +: EntW] = {tg_n[i], ag_n[i], dt_n[i], vl_n[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      set_q <= set_in;
      tag_q <= TagW'(addr_m >> Shift);
    end
    if (cmd_i.lookup) begin
      hit_q <= hit;
      way_q <= satsl_pkg::WayOutW'(way);
      wb_q  <= wb;
      wba_q <= wba;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cmd_i.lookup) begin
      init_q[set_q] <= 1'b1;
    end
  end

  assign hit_o            = hit_q;
  assign way_o            = way_q;
  assign writeback_o      = wb_q;
  assign writeback_addr_o = wba_q;

endmodule

[hdl/set_assoc_tag_store_lru.sv]
// Top level of the set-associative tag store with aging-counter replacement.
// Depends on satsl_pkg, satsl_ctrl, satsl_dp (and satsl_ram through it).
//
// Usage:
//   Request channel: in_valid_i / in_ready_o with op_i (0 read, 1 write)
//   and addr_i. Result channel: out_valid_o / out_ready_i with hit_o,
//   way_o, writeback_o and writeback_addr_o; one result per request.
//   The set row of a request is read from the RAM at the accept edge,
//   then compared, aged and written back in the lookup cycle, at whose end
//   the result is registered and becomes valid.
//   No request is accepted during the lookup cycle; the next request is
//   taken in the cycle its predecessor's result is taken, so requests do
//   not overlap.
//   Stall: while out_ready_i is low a pending result holds and no new
//   request is accepted.
//   Reset: all sets read as empty (invalid, clean, ages zero) through one
//   written flag per set; no clearing pass is needed.
module set_assoc_tag_store_lru #(
  parameter int unsigned Sets       = satsl_pkg::DefSets,
  parameter int unsigned Ways       = satsl_pkg::DefWays,
  parameter int unsigned BlockBytes = satsl_pkg::DefBlockBytes,
  parameter int unsigned AgeBits    = satsl_pkg::DefAgeBits,
  parameter int unsigned AddrBits   = satsl_pkg::DefAddrBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [satsl_pkg::AddrW-1:0]   addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [satsl_pkg::WayOutW-1:0] way_o,
  output logic                          writeback_o,
  output logic [satsl_pkg::AddrW-1:0]   writeback_addr_o
);

  satsl_pkg::cmd_t cmd;

  satsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  satsl_dp #(
    .Sets       (Sets),
    .Ways       (Ways),
    .BlockBytes (BlockBytes),
    .AgeBits    (AgeBits),
    .AddrBits   (AddrBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (op_i),
    .addr_i           (addr_i),
    .hit_o            (hit_o),
    .way_o            (way_o),
    .writeback_o      (writeback_o),
    .writeback_addr_o (writeback_addr_o)
  );

endmodule
